// ----- hdl/shuffle_and_draw_cards_assert.svh -----
// assertion macros used by the checker file
`ifndef SHUFFLE_AND_DRAW_CARDS_ASSERT_SVH
`define SHUFFLE_AND_DRAW_CARDS_ASSERT_SVH

// property checked outside reset only
`define SDC_ASSERT(lbl, prop) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (prop)) \
        else $error("assertion failed");

// property that must also hold across reset
`define SDC_ASSERT_RST(lbl, prop) \
    lbl: assert property (@(posedge i_clk) (prop)) \
        else $error("assertion failed");

`endif

// ----- hdl/sdc_pkg.sv -----
package sdc_pkg;

    // deck geometry
    localparam int DECK_SIZE = 78;
    localparam int IDX_W     = $clog2(DECK_SIZE);
    localparam int CNT_W     = $clog2(DECK_SIZE + 1);

    // field widths
    localparam int WORD_W = 32;
    localparam int CFG_W  = 7;
    localparam int OUT_W  = 7;
    localparam int DIV_W  = (CNT_W > CFG_W) ? CNT_W : CFG_W;
    localparam int CMP_W  = (CNT_W > CFG_W) ? CNT_W : CFG_W;
    localparam int STEP_W = $clog2(WORD_W);

    // constants
    localparam int REV_MOD    = 100;
    localparam int DRAW_RESET = 1;
    localparam int REV_RESET  = 30;

    // configuration register indexes
    localparam int CFG_AW = 1;
    localparam logic [CFG_AW-1:0] REG_DRAW_COUNT = 1'b0;
    localparam logic [CFG_AW-1:0] REG_REV_PCT    = 1'b1;

    // controller states
    typedef enum logic [7:0] {
        S_IDLE = 8'b0000_0001,
        S_DIV  = 8'b0000_0010,
        S_RD_I = 8'b0000_0100,
        S_RD_J = 8'b0000_1000,
        S_WR_I = 8'b0001_0000,
        S_WR_J = 8'b0010_0000,
        S_RD_P = 8'b0100_0000,
        S_OUT  = 8'b1000_0000
    } t_state;

    // controller to datapath commands
    typedef struct packed {
        logic load;
        logic div_step;
        logic rd_i;
        logic rd_j;
        logic wr_i;
        logic wr_j;
        logic rd_p;
        logic out_load;
    } t_dp_cmd;

    // datapath to controller status
    typedef struct packed {
        logic div_last;
        logic dealing;
        logic out_free;
    } t_dp_sts;

endpackage

// ----- hdl/sdc_ram.sv -----
module sdc_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // write port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // registered read port
    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ----- hdl/sdc_ctrl.sv -----
module sdc_ctrl (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_valid,
    output logic             o_ready,
    input  sdc_pkg::t_dp_sts i_sts,
    output sdc_pkg::t_dp_cmd o_cmd
);

    sdc_pkg::t_state r_state;
    sdc_pkg::t_state n_state;

    // state register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= sdc_pkg::S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // next state and commands
    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        case (r_state)
            sdc_pkg::S_IDLE: begin
                if (i_valid) begin
                    o_cmd.load = 1'b1;
                    n_state    = sdc_pkg::S_DIV;
                end
            end
            sdc_pkg::S_DIV: begin
                o_cmd.div_step = 1'b1;
                if (i_sts.div_last) begin
                    n_state = i_sts.dealing ? sdc_pkg::S_RD_P : sdc_pkg::S_RD_I;
                end
            end
            sdc_pkg::S_RD_I: begin
                o_cmd.rd_i = 1'b1;
                n_state    = sdc_pkg::S_RD_J;
            end
            sdc_pkg::S_RD_J: begin
                o_cmd.rd_j = 1'b1;
                n_state    = sdc_pkg::S_WR_I;
            end
            sdc_pkg::S_WR_I: begin
                o_cmd.wr_i = 1'b1;
                n_state    = sdc_pkg::S_WR_J;
            end
            sdc_pkg::S_WR_J: begin
                o_cmd.wr_j = 1'b1;
                n_state    = sdc_pkg::S_IDLE;
            end
            sdc_pkg::S_RD_P: begin
                o_cmd.rd_p = 1'b1;
                n_state    = sdc_pkg::S_OUT;
            end
            sdc_pkg::S_OUT: begin
                if (i_sts.out_free) begin
                    o_cmd.out_load = 1'b1;
                    n_state        = sdc_pkg::S_IDLE;
                end
            end
            default: begin
                n_state = sdc_pkg::S_IDLE;
            end
        endcase
    end

    assign o_ready = (r_state == sdc_pkg::S_IDLE);

endmodule

// ----- hdl/sdc_dp.sv -----
module sdc_dp (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  sdc_pkg::t_dp_cmd                  i_cmd,
    output sdc_pkg::t_dp_sts                  o_sts,
    input  logic [sdc_pkg::WORD_W-1:0]        i_random_word,
    input  logic                              i_cfg_we,
    input  logic [sdc_pkg::CFG_AW-1:0]        i_cfg_addr,
    input  logic [sdc_pkg::CFG_W-1:0]         i_cfg_data,
    input  logic                              i_ready,
    output logic                              o_valid,
    output logic [sdc_pkg::OUT_W-1:0]         o_card_id,
    output logic                              o_is_reversed,
    output logic [sdc_pkg::OUT_W-1:0]         o_position_index,
    output logic                              o_last_card
);

    // configuration registers
    logic [sdc_pkg::CFG_W-1:0] r_draw_count;
    logic [sdc_pkg::CFG_W-1:0] r_rev_pct;

    // shuffle and deal state
    logic [sdc_pkg::IDX_W-1:0]     r_swap;
    logic                          r_dealing;
    logic [sdc_pkg::IDX_W-1:0]     r_pos;
    logic [sdc_pkg::DECK_SIZE-1:0] r_vld;

    // remainder unit
    logic [sdc_pkg::WORD_W-1:0] r_word;
    logic [sdc_pkg::DIV_W-1:0]  r_rem;
    logic [sdc_pkg::DIV_W-1:0]  n_rem;
    logic [sdc_pkg::STEP_W-1:0] r_step;
    logic [sdc_pkg::DIV_W-1:0]  w_div;
    logic [sdc_pkg::DIV_W:0]    w_trial;

    // deck memory access
    logic                      w_re;
    logic [sdc_pkg::IDX_W-1:0] w_raddr;
    logic                      w_we;
    logic [sdc_pkg::IDX_W-1:0] w_waddr;
    logic [sdc_pkg::IDX_W-1:0] w_wdata;
    logic [sdc_pkg::IDX_W-1:0] w_q;
    logic [sdc_pkg::IDX_W-1:0] r_rd_addr;
    logic [sdc_pkg::IDX_W-1:0] w_card;
    logic [sdc_pkg::IDX_W-1:0] r_val_i;
    logic [sdc_pkg::IDX_W-1:0] w_j;

    // deal decisions
    logic [sdc_pkg::CMP_W-1:0] w_cnt;
    logic [sdc_pkg::CMP_W-1:0] w_pos1;
    logic                      w_last;
    logic                      w_rev;

    // output register
    logic                      r_out_valid;
    logic [sdc_pkg::OUT_W-1:0] r_out_card;
    logic                      r_out_rev;
    logic [sdc_pkg::OUT_W-1:0] r_out_pos;
    logic                      r_out_last;

    // configuration writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_draw_count <= sdc_pkg::CFG_W'(sdc_pkg::DRAW_RESET);
            r_rev_pct    <= sdc_pkg::CFG_W'(sdc_pkg::REV_RESET);
        end else if (i_cfg_we) begin
            case (i_cfg_addr)
                sdc_pkg::REG_DRAW_COUNT: r_draw_count <= i_cfg_data;
                sdc_pkg::REG_REV_PCT:    r_rev_pct    <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // divisor: swap index plus one while shuffling, 100 while dealing
    assign w_div = r_dealing ? sdc_pkg::DIV_W'(sdc_pkg::REV_MOD)
                             : sdc_pkg::DIV_W'(r_swap) + sdc_pkg::DIV_W'(1);

    // restoring remainder step, one word bit per cycle
    always_comb begin
        w_trial = {r_rem, r_word[sdc_pkg::WORD_W-1]};
        if (w_trial >= {1'b0, w_div}) begin
            n_rem = sdc_pkg::DIV_W'(w_trial - {1'b0, w_div});
        end else begin
            n_rem = w_trial[sdc_pkg::DIV_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_word <= i_random_word;
            r_rem  <= '0;
            r_step <= '0;
        end else if (i_cmd.div_step) begin
            r_word <= r_word << 1;
            r_rem  <= n_rem;
            r_step <= r_step + sdc_pkg::STEP_W'(1);
        end
    end

    assign w_j = sdc_pkg::IDX_W'(r_rem);

    // memory address and data selection
    always_comb begin
        w_re    = i_cmd.rd_i | i_cmd.rd_j | i_cmd.rd_p;
        w_raddr = r_pos;
        if (i_cmd.rd_i) begin
            w_raddr = r_swap;
        end else if (i_cmd.rd_j) begin
            w_raddr = w_j;
        end
        w_we    = i_cmd.wr_i | i_cmd.wr_j;
        w_waddr = i_cmd.wr_i ? r_swap : w_j;
        w_wdata = i_cmd.wr_i ? w_card : r_val_i;
    end

    sdc_ram #(
        .WIDTH (sdc_pkg::IDX_W),
        .DEPTH (sdc_pkg::DECK_SIZE)
    ) u_deck (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (w_waddr),
        .i_wdata (w_wdata),
        .i_re    (w_re),
        .i_raddr (w_raddr),
        .o_rdata (w_q)
    );

    // an entry not written since the last restart holds its own index
    assign w_card = r_vld[r_rd_addr] ? w_q : r_rd_addr;

    always_ff @(posedge i_clk) begin
        if (w_re) begin
            r_rd_addr <= w_raddr;
        end
        if (i_cmd.rd_j) begin
            r_val_i <= w_card;
        end
    end

    // effective draw count, clamped to one through the deck size
    always_comb begin
        w_cnt = sdc_pkg::CMP_W'(r_draw_count);
        if (w_cnt == '0) begin
            w_cnt = sdc_pkg::CMP_W'(1);
        end else if (w_cnt > sdc_pkg::CMP_W'(sdc_pkg::DECK_SIZE)) begin
            w_cnt = sdc_pkg::CMP_W'(sdc_pkg::DECK_SIZE);
        end
        w_pos1 = sdc_pkg::CMP_W'(r_pos) + sdc_pkg::CMP_W'(1);
        w_last = (w_pos1 >= w_cnt);
        w_rev  = (r_rem < sdc_pkg::DIV_W'(r_rev_pct));
    end

    // shuffle and deal state, valid bits
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_swap    <= sdc_pkg::IDX_W'(sdc_pkg::DECK_SIZE - 1);
            r_dealing <= 1'b0;
            r_pos     <= '0;
            r_vld     <= '0;
        end else begin
            if (w_we) begin
                r_vld[w_waddr] <= 1'b1;
            end
            if (i_cmd.wr_j) begin
                if (r_swap <= sdc_pkg::IDX_W'(1)) begin
                    r_dealing <= 1'b1;
                    r_pos     <= '0;
                    r_swap    <= '0;
                end else begin
                    r_swap <= r_swap - sdc_pkg::IDX_W'(1);
                end
            end
            if (i_cmd.out_load) begin
                if (w_last) begin
                    r_swap    <= sdc_pkg::IDX_W'(sdc_pkg::DECK_SIZE - 1);
                    r_dealing <= 1'b0;
                    r_pos     <= '0;
                    r_vld     <= '0;
                end else begin
                    r_pos <= r_pos + sdc_pkg::IDX_W'(1);
                end
            end
        end
    end

    // output register, holds while the receiver stalls
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.out_load) begin
            r_out_valid <= 1'b1;
        end else if (i_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.out_load) begin
            r_out_card <= sdc_pkg::OUT_W'(w_card);
            r_out_rev  <= w_rev;
            r_out_pos  <= sdc_pkg::OUT_W'(r_pos);
            r_out_last <= w_last;
        end
    end

    assign o_sts.div_last = (r_step == sdc_pkg::STEP_W'(sdc_pkg::WORD_W - 1));
    assign o_sts.dealing  = r_dealing;
    assign o_sts.out_free = !r_out_valid || i_ready;

    assign o_valid          = r_out_valid;
    assign o_card_id        = r_out_card;
    assign o_is_reversed    = r_out_rev;
    assign o_position_index = r_out_pos;
    assign o_last_card      = r_out_last;

endmodule

// ----- hdl/shuffle_and_draw_cards.sv -----
// Card shuffler and dealer fed by 32-bit random words.
// Input channel: i_valid / o_ready carry one random word per transaction.
// While shuffling, each word does one deck swap and gives no result; once
// DECK_SIZE-1 swaps are done, each word deals one card on the output channel
// (o_valid / i_ready) with its position, reversed flag and last-card mark.
// After the last card the deck returns to identity order and shuffling
// starts again.
// Flow: one transaction at a time. Each word runs through a bit-serial
// remainder unit; a shuffle word then needs two deck memory reads and two
// writes before o_ready returns. A deal word needs one memory read and an
// output step; the card is on o_valid in the same cycle o_ready returns.
// The deck memory has one port of each kind, which sets the swap length.
// Reset (synchronous, i_rst_n low) restores identity order at once through
// per-entry valid bits, loads draw_count 1 and reversal_percent 30.
// A stalled receiver holds the card in the output register; the next word is
// still taken and worked on, and waits only to hand over its card.
// Configuration writes (i_cfg_we) are for the user to make only while the
// block is idle; the block itself does not enforce this.
module shuffle_and_draw_cards (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_valid,
    output logic                       o_ready,
    input  logic [sdc_pkg::WORD_W-1:0] i_random_word,
    output logic                       o_valid,
    input  logic                       i_ready,
    output logic [sdc_pkg::OUT_W-1:0]  o_card_id,
    output logic                       o_is_reversed,
    output logic [sdc_pkg::OUT_W-1:0]  o_position_index,
    output logic                       o_last_card,
    input  logic                       i_cfg_we,
    input  logic [sdc_pkg::CFG_AW-1:0] i_cfg_addr,
    input  logic [sdc_pkg::CFG_W-1:0]  i_cfg_data
);

    sdc_pkg::t_dp_cmd w_cmd;
    sdc_pkg::t_dp_sts w_sts;

    // sequencing
    sdc_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_ready (o_ready),
        .i_sts   (w_sts),
        .o_cmd   (w_cmd)
    );

    // deck, remainder unit and output register
    sdc_dp u_dp (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cmd            (w_cmd),
        .o_sts            (w_sts),
        .i_random_word    (i_random_word),
        .i_cfg_we         (i_cfg_we),
        .i_cfg_addr       (i_cfg_addr),
        .i_cfg_data       (i_cfg_data),
        .i_ready          (i_ready),
        .o_valid          (o_valid),
        .o_card_id        (o_card_id),
        .o_is_reversed    (o_is_reversed),
        .o_position_index (o_position_index),
        .o_last_card      (o_last_card)
    );

endmodule

// ----- hdl/sdc_checker.sv -----
`include "shuffle_and_draw_cards_assert.svh"

module sdc_checker (
    input logic                       i_clk,
    input logic                       i_rst_n,
    input logic                       i_valid,
    input logic                       o_ready,
    input logic [sdc_pkg::WORD_W-1:0] i_random_word,
    input logic                       o_valid,
    input logic                       i_ready,
    input logic [sdc_pkg::OUT_W-1:0]  o_card_id,
    input logic                       o_is_reversed,
    input logic [sdc_pkg::OUT_W-1:0]  o_position_index,
    input logic                       o_last_card,
    input logic                       i_cfg_we,
    input logic [sdc_pkg::CFG_AW-1:0] i_cfg_addr,
    input logic [sdc_pkg::CFG_W-1:0]  i_cfg_data
);

    // output payload gathered for the hold check
    logic [2*sdc_pkg::OUT_W+1:0] w_out_bus;

    assign w_out_bus = {o_card_id, o_is_reversed, o_position_index, o_last_card};

    // reset leaves the block ready with no card pending
    `SDC_ASSERT_RST(a_reset_state, !i_rst_n |=> (o_ready && !o_valid))

    // one word at a time: ready drops after each accepted transaction
    `SDC_ASSERT(a_one_at_a_time, (i_valid && o_ready) |=> !o_ready)

    // a card never appears in the cycle right after a word is taken
    `SDC_ASSERT(a_no_early_card, (i_valid && o_ready && !o_valid) |=> !o_valid)

    // stalled card holds its payload
    `SDC_ASSERT(a_out_hold, (o_valid && !i_ready) |=> (o_valid && $stable(w_out_bus)))

endmodule

bind shuffle_and_draw_cards sdc_checker u_sdc_checker (.*);

// ----- bench/tb_top.sv -----
module tb_top;

    localparam int CLK_HALF      = 5;
    localparam int SETTLE_CYCLES = 50;
    localparam int HOLD_CYCLES   = 300;
    localparam int CYCLE_LIMIT   = 1_000_000;
    localparam int REPORT_CAP    = 200;
    localparam int RANDOM_WORDS  = 160;
    localparam int RANDOM_CARDS  = 16;

    // one dealt card as seen on the output channel
    typedef struct packed {
        logic [sdc_pkg::OUT_W-1:0] card_id;
        logic                      reversed;
        logic [sdc_pkg::OUT_W-1:0] position;
        logic                      last;
    } t_card;

    logic                         i_clk         = 1'b0;
    logic                         i_rst_n       = 1'b0;
    logic                         i_valid       = 1'b0;
    logic                         o_ready;
    logic [sdc_pkg::WORD_W-1:0]   i_random_word = '0;
    logic                         o_valid;
    logic                         i_ready       = 1'b0;
    logic [sdc_pkg::OUT_W-1:0]    o_card_id;
    logic                         o_is_reversed;
    logic [sdc_pkg::OUT_W-1:0]    o_position_index;
    logic                         o_last_card;
    logic                         i_cfg_we      = 1'b0;
    logic [sdc_pkg::CFG_AW-1:0]   i_cfg_addr    = '0;
    logic [sdc_pkg::CFG_W-1:0]    i_cfg_data    = '0;

    // shadow of the shuffler state
    logic [sdc_pkg::OUT_W-1:0]    deck_order [sdc_pkg::DECK_SIZE];
    int unsigned                  swap_at;
    bit                           dealing;
    int unsigned                  deal_at;
    logic [sdc_pkg::CFG_W-1:0]    draw_setting;
    logic [sdc_pkg::CFG_W-1:0]    rev_setting;

    t_card                        cards_due [$];
    int                           mismatches   = 0;
    int                           cards_dealt  = 0;
    int                           words_sent   = 0;
    int                           cycle_count  = 0;

    // idling controls
    bit                           tx_quiet     = 1'b0;
    bit                           rx_quiet     = 1'b0;
    bit                           hold_request = 1'b0;
    int                           hold_left    = 0;
    int                           rx_stall     = 0;

    shuffle_and_draw_cards i_dut (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_valid          (i_valid),
        .o_ready          (o_ready),
        .i_random_word    (i_random_word),
        .o_valid          (o_valid),
        .i_ready          (i_ready),
        .o_card_id        (o_card_id),
        .o_is_reversed    (o_is_reversed),
        .o_position_index (o_position_index),
        .o_last_card      (o_last_card),
        .i_cfg_we         (i_cfg_we),
        .i_cfg_addr       (i_cfg_addr),
        .i_cfg_data       (i_cfg_data)
    );

    initial begin
        forever #CLK_HALF i_clk = ~i_clk;
    end

    // run watchdog
    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("%0t: run did not finish within %0d cycles", $time, CYCLE_LIMIT);
            $display("shuffle_and_draw_cards: mismatch");
            $finish;
        end
    end

    // identity order, shuffle restarts from the top
    task automatic restore_deck();
        for (int k = 0; k < sdc_pkg::DECK_SIZE; k++) deck_order[k] = sdc_pkg::OUT_W'(k);
        swap_at = sdc_pkg::DECK_SIZE - 1;
        dealing = 1'b0;
        deal_at = 0;
    endtask

    // one word: a swap while shuffling, a card while dealing
    task automatic apply_word(input logic [sdc_pkg::WORD_W-1:0] word);
        int unsigned               i;
        int unsigned               j;
        int unsigned               n;
        int unsigned               p;
        logic [sdc_pkg::OUT_W-1:0] t;
        t_card                     c;
        if (!dealing) begin
            i = (swap_at >= sdc_pkg::DECK_SIZE) ? sdc_pkg::DECK_SIZE - 1 : swap_at;
            if (i == 0) begin
                dealing = 1'b1;
                deal_at = 0;
            end else begin
                j = word % (i + 1);
                t             = deck_order[i];
                deck_order[i] = deck_order[j];
                deck_order[j] = t;
                if (i <= 1) begin
                    dealing = 1'b1;
                    deal_at = 0;
                    swap_at = 0;
                end else begin
                    swap_at = i - 1;
                end
            end
        end else begin
            n = draw_setting;
            if (n == 0) n = 1;
            if (n > sdc_pkg::DECK_SIZE) n = sdc_pkg::DECK_SIZE;
            p = (deal_at >= sdc_pkg::DECK_SIZE) ? sdc_pkg::DECK_SIZE - 1 : deal_at;
            c.card_id  = deck_order[p];
            c.reversed = (word % sdc_pkg::REV_MOD) < rev_setting;
            c.position = sdc_pkg::OUT_W'(p);
            c.last     = (p + 1) >= n;
            cards_due  = {cards_due, c};
            cards_dealt++;
            if (c.last) restore_deck();
            else deal_at = p + 1;
        end
    endtask

    task automatic compare_field(input string name, input int unsigned want,
                                 input logic [sdc_pkg::OUT_W-1:0] got);
        if (got !== sdc_pkg::OUT_W'(want)) begin
            mismatches++;
            if (mismatches <= REPORT_CAP)
                $display("%0t: %s expected %0d actual %0d", $time, name, want, got);
        end
    endtask

    // compare one accepted card with the oldest one due
    task automatic check_card();
        t_card want;
        if (cards_due.size() == 0) begin
            mismatches++;
            if (mismatches <= REPORT_CAP)
                $display("%0t: card expected none actual id %0d pos %0d", $time,
                         o_card_id, o_position_index);
            return;
        end
        want = cards_due.pop_front();
        compare_field("card_id", want.card_id, o_card_id);
        compare_field("is_reversed", want.reversed, o_is_reversed);
        compare_field("position_index", want.position, o_position_index);
        compare_field("last_card", want.last, o_last_card);
    endtask

    // receiving side: check each transaction, then choose the next ready
    always @(posedge i_clk) begin
        if (i_rst_n && o_valid && i_ready) check_card();
        if (hold_request) begin
            hold_left    = HOLD_CYCLES;
            hold_request = 1'b0;
        end
        if (hold_left > 0) begin
            hold_left--;
            i_ready <= 1'b0;
        end else if (rx_stall > 0) begin
            rx_stall--;
            i_ready <= 1'b0;
        end else begin
            i_ready <= 1'b1;
            if (!rx_quiet) begin
                case ($urandom_range(0, 99)) inside
                    [0:19]:  rx_stall = $urandom_range(1, 3);
                    [20:22]: rx_stall = $urandom_range(15, 60);
                    default: rx_stall = 0;
                endcase
            end
        end
    end

    function automatic int pick_gap();
        if (tx_quiet) return 0;
        case ($urandom_range(0, 99)) inside
            [0:59]:  return 0;
            [60:93]: return $urandom_range(1, 3);
            default: return $urandom_range(10, 40);
        endcase
    endfunction

    // mostly uniform words, some near the ends and near the reversal boundary
    function automatic logic [sdc_pkg::WORD_W-1:0] pick_word();
        case ($urandom_range(0, 9))
            0:       return $urandom_range(0, 255);
            1:       return 32'hFFFF_FFFF - $urandom_range(0, 255);
            2:       return $urandom_range(0, 40_000_000) * sdc_pkg::REV_MOD + rev_setting
                            + $urandom_range(0, 2) - 1;
            default: return $urandom;
        endcase
    endfunction

    task automatic send_word(input logic [sdc_pkg::WORD_W-1:0] word);
        int gap;
        gap = pick_gap();
        if (gap > 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_valid       <= 1'b1;
        i_random_word <= word;
        @(posedge i_clk);
        while (!o_ready) @(posedge i_clk);
        apply_word(word);
        words_sent++;
    endtask

    // wait until every card is in and the last swap is surely done
    task automatic settle();
        i_valid <= 1'b0;
        while (cards_due.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [sdc_pkg::CFG_AW-1:0] idx,
                             input logic [sdc_pkg::CFG_W-1:0] val);
        @(posedge i_clk);
        i_cfg_we   <= 1'b1;
        i_cfg_addr <= idx;
        i_cfg_data <= val;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        if (idx == sdc_pkg::REG_DRAW_COUNT) draw_setting = val;
        else if (idx == sdc_pkg::REG_REV_PCT) rev_setting = val;
    endtask

    task automatic shuffle_deck();
        repeat (sdc_pkg::DECK_SIZE - 1) send_word(pick_word());
    endtask

    // reset settings: one card per deal, threshold 30
    task automatic test_reset_settings();
        send_word(32'h0000_0000);
        send_word(32'hFFFF_FFFF);
        send_word(32'h8000_0000);
        repeat (sdc_pkg::DECK_SIZE - 4) send_word(pick_word());
        send_word(32'd29);
        shuffle_deck();
        send_word(32'd30);
    endtask

    // draw count 0 and above the deck, thresholds 0 and above 100
    task automatic test_count_bounds();
        settle();
        write_reg(sdc_pkg::REG_DRAW_COUNT, 7'd0);
        write_reg(sdc_pkg::REG_REV_PCT, 7'd0);
        shuffle_deck();
        send_word(32'd0);
        settle();
        write_reg(sdc_pkg::REG_DRAW_COUNT, 7'd127);
        write_reg(sdc_pkg::REG_REV_PCT, 7'd127);
        shuffle_deck();
        repeat (sdc_pkg::DECK_SIZE - 1) send_word(pick_word());
        send_word(32'hFFFF_FFFF);
    endtask

    // draw count lowered in the middle of a deal
    task automatic test_count_change();
        settle();
        write_reg(sdc_pkg::REG_DRAW_COUNT, 7'd20);
        write_reg(sdc_pkg::REG_REV_PCT, 7'd50);
        shuffle_deck();
        repeat (6) send_word(pick_word());
        settle();
        write_reg(sdc_pkg::REG_DRAW_COUNT, 7'd3);
        send_word(32'd49);
    endtask

    // full deal while the receiver holds off, so the input stalls
    task automatic test_backpressure();
        settle();
        write_reg(sdc_pkg::REG_DRAW_COUNT, 7'(sdc_pkg::DECK_SIZE));
        write_reg(sdc_pkg::REG_REV_PCT, 7'd100);
        shuffle_deck();
        hold_request = 1'b1;
        send_word(32'd99);
        repeat (sdc_pkg::DECK_SIZE - 1) send_word(pick_word());
    endtask

    // random phases with random settings written in between
    task automatic test_random();
        int first_word;
        int first_card;
        int len;
        first_word = words_sent;
        first_card = cards_dealt;
        while (words_sent - first_word < RANDOM_WORDS
               || cards_dealt - first_card < RANDOM_CARDS) begin
            settle();
            if ($urandom_range(0, 3) != 0) begin
                case ($urandom_range(0, 9))
                    0:       write_reg(sdc_pkg::REG_DRAW_COUNT, 7'd0);
                    1:       write_reg(sdc_pkg::REG_DRAW_COUNT, 7'd127);
                    2:       write_reg(sdc_pkg::REG_DRAW_COUNT, 7'(sdc_pkg::DECK_SIZE));
                    3:       write_reg(sdc_pkg::REG_DRAW_COUNT, 7'd1);
                    default: write_reg(sdc_pkg::REG_DRAW_COUNT,
                                       7'($urandom_range(1, sdc_pkg::DECK_SIZE)));
                endcase
            end
            if ($urandom_range(0, 3) != 0) begin
                case ($urandom_range(0, 9))
                    0:       write_reg(sdc_pkg::REG_REV_PCT, 7'd0);
                    1:       write_reg(sdc_pkg::REG_REV_PCT, 7'd100);
                    2:       write_reg(sdc_pkg::REG_REV_PCT, 7'd127);
                    default: write_reg(sdc_pkg::REG_REV_PCT, 7'($urandom_range(0, 100)));
                endcase
            end
            tx_quiet = ($urandom_range(0, 4) == 0);
            rx_quiet = ($urandom_range(0, 4) == 0);
            len = $urandom_range(10, 160);
            repeat (len) send_word(pick_word());
        end
        tx_quiet = 1'b0;
        rx_quiet = 1'b0;
    endtask

    initial begin
        restore_deck();
        draw_setting = 7'(sdc_pkg::DRAW_RESET);
        rev_setting  = 7'(sdc_pkg::REV_RESET);
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_reset_settings();
        test_count_bounds();
        test_count_change();
        test_backpressure();
        test_random();

        settle();
        if (mismatches == 0) begin
            $display("shuffle_and_draw_cards: match");
        end else begin
            $display("shuffle_and_draw_cards: mismatch");
        end
        $finish;
    end

endmodule

// ----- filelist.f -----
+incdir+hdl
hdl/sdc_pkg.sv
hdl/sdc_ram.sv
hdl/sdc_ctrl.sv
hdl/sdc_dp.sv
hdl/shuffle_and_draw_cards.sv
hdl/sdc_checker.sv
bench/tb_top.sv
